// ===== design/mfp_pkg.sv =====
// mfp_pkg: request modes, result status codes and the message record
// shared by the message queue and its checker.
// no dependencies.
package mfp_pkg;

	localparam int ARG_W = 32;

	typedef enum logic [2:0] {
		MODE_PUT   = 3'd0,
		MODE_GET   = 3'd1,
		MODE_FLUSH = 3'd2,
		MODE_PURGE = 3'd3,
		MODE_ABORT = 3'd4,
		MODE_START = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_ABORTED = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// one queued message, type code in the low bits
	typedef struct packed {
		logic signed [ARG_W-1:0] arg2;
		logic signed [ARG_W-1:0] arg1;
		logic signed [ARG_W-1:0] kind;
	} msg_t;

	localparam int MSG_W = $bits(msg_t);

endpackage

// ===== design/mfp_out_buf.sv =====
// mfp_out_buf: two-entry registered result buffer on the master side of the
// message queue. depends on nothing but its width parameter.
module mfp_out_buf #(
	parameter int W = 105
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         room,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic [1:0]   cnt_q;
	logic [W-1:0] slot0_q;
	logic [W-1:0] slot1_q;
	logic         pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign room      = (cnt_q != 2'd2);
	assign out_data  = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case (cnt_q)
				2'd0: begin
					if (push) cnt_q <= 2'd1;
				end
				2'd1: begin
					if (pop && !push) cnt_q <= 2'd0;
					else if (push && !pop) cnt_q <= 2'd2;
				end
				2'd2: begin
					if (pop) cnt_q <= 2'd1;
				end
				default: cnt_q <= 2'd0;
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		unique case (cnt_q)
			2'd0: begin
				if (push) slot0_q <= push_data;
			end
			2'd1: begin
				if (push && pop) slot0_q <= push_data;
				else if (push) slot1_q <= push_data;
			end
			2'd2: begin
				if (pop) slot0_q <= slot1_q;
			end
			default: slot0_q <= slot0_q;
		endcase
	end

endmodule

// ===== design/message_fifo_with_purge.sv =====
// message_fifo_with_purge: bounded message queue with put, get, flush,
// purge by type, abort and start. depends on mfp_pkg and mfp_out_buf.
//
// usage
//   s_* : one request per transaction. s_tuser holds the mode, s_tdata the
//         message type (or the type to purge) and the two arguments.
//   m_* : exactly one result per request, in request order. m_tuser holds
//         the status, m_tdata the popped message (zero unless a get
//         delivered one) and the occupancy after the request.
//   cfg_*: writes the type code of the message start enqueues; always ready.
//         user writes only while no request is outstanding; not enforced.
// latency and throughput
//   put, flush, abort, start and every refused request finish at the edge
//   that accepts them. get with data waits for the store read and returns
//   its result in the cycle after acceptance.
//   purge streams the queue through the store at one entry per cycle,
//   reading one entry while writing back a kept one.
// reset
//   the queue comes out of reset empty and aborted; a start is needed before
//   put or get succeed. the store itself is not cleared.
// receiver stall
//   results go through a two-entry buffer, so a request is still taken while
//   one result waits; s_tready drops once two results are waiting.
module message_fifo_with_purge
	import mfp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	// request: mode
	input  logic [2:0] s_tuser,
	// request, low bit first: msg_type[31:0], arg_first[31:0], arg_second[31:0]
	input  logic [95:0] s_tdata,
	input  logic s_tvalid,
	output logic s_tready,
	// result: status
	output logic [1:0] m_tuser,
	// result, low bit first: out_type[31:0], out_arg_first[31:0],
	// out_arg_second[31:0], occupancy, zero padding to a whole byte
	output logic [((3*32+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// flush_type_code write
	input  logic [31:0] cfg_data,
	input  logic cfg_valid,
	output logic cfg_ready
);

	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int RES_W  = 2 + MSG_W + CNT_W;
	localparam int ODAT_W = ((MSG_W + CNT_W + 7) / 8) * 8;
	localparam int PAD_W  = ODAT_W - MSG_W - CNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_GET,
		S_PURGE
	} state_t;

	function automatic logic [IDX_W-1:0] nxt_pos(input logic [IDX_W-1:0] p);
		nxt_pos = (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// control state
	state_t            state_q, state_nx;
	logic [IDX_W-1:0]  head_q, head_nx;
	logic [IDX_W-1:0]  tail_q, tail_nx;
	logic [CNT_W-1:0]  cnt_q, cnt_nx;
	logic              abort_q, abort_nx;
	logic [ARG_W-1:0]  flush_code_q;
	// purge walk
	logic [IDX_W-1:0]  rd_q, rd_nx;
	logic [IDX_W-1:0]  wr_q, wr_nx;
	logic [CNT_W-1:0]  iss_q, iss_nx;
	logic [CNT_W-1:0]  kept_q, kept_nx;
	logic [ARG_W-1:0]  ptype_q, ptype_nx;

	// message store, one read and one write port
	msg_t              store_q [QUEUE_DEPTH];
	msg_t              rd_data_s1;
	logic              we;
	logic [IDX_W-1:0]  wa;
	logic [IDX_W-1:0]  ra;
	msg_t              wd;

	// result path
	logic              acc;
	logic              room;
	logic              push;
	status_t           res_status;
	msg_t              res_msg;
	logic [RES_W-1:0]  res_data;
	logic [RES_W-1:0]  buf_data;
	logic              full;
	logic              keep;
	msg_t              in_msg;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE) && room;
	assign acc       = s_tvalid && s_tready;
	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign in_msg    = s_tdata;
	assign keep      = (rd_data_s1.kind != ptype_q);

	always_comb begin
		state_nx   = state_q;
		head_nx    = head_q;
		tail_nx    = tail_q;
		cnt_nx     = cnt_q;
		abort_nx   = abort_q;
		rd_nx      = rd_q;
		wr_nx      = wr_q;
		iss_nx     = iss_q;
		kept_nx    = kept_q;
		ptype_nx   = ptype_q;
		we         = 1'b0;
		wa         = tail_q;
		wd         = in_msg;
		ra         = head_q;
		push       = 1'b0;
		res_status = ST_OK;
		res_msg    = '0;

		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (mode_t'(s_tuser))
						MODE_PUT: begin
							push = 1'b1;
							if (abort_q) begin
								res_status = ST_ABORTED;
							end else if (full) begin
								res_status = ST_FULL;
							end else begin
								we      = 1'b1;
								tail_nx = nxt_pos(tail_q);
								cnt_nx  = cnt_q + 1'b1;
							end
						end
						MODE_GET: begin
							// store read of the head goes out this cycle
							if (abort_q) begin
								push       = 1'b1;
								res_status = ST_ABORTED;
							end else if (cnt_q == '0) begin
								push       = 1'b1;
								res_status = ST_EMPTY;
							end else begin
								state_nx = S_GET;
							end
						end
						MODE_FLUSH: begin
							push    = 1'b1;
							head_nx = '0;
							tail_nx = '0;
							cnt_nx  = '0;
						end
						MODE_PURGE: begin
							if (abort_q) begin
								push       = 1'b1;
								res_status = ST_ABORTED;
							end else if (cnt_q == '0) begin
								push = 1'b1;
							end else begin
								rd_nx    = nxt_pos(head_q);
								wr_nx    = head_q;
								iss_nx   = CNT_W'(1);
								kept_nx  = '0;
								ptype_nx = in_msg.kind;
								state_nx = S_PURGE;
							end
						end
						MODE_ABORT: begin
							push     = 1'b1;
							abort_nx = 1'b1;
						end
						MODE_START: begin
							push     = 1'b1;
							abort_nx = 1'b0;
							if (full) begin
								res_status = ST_FULL;
							end else begin
								we      = 1'b1;
								wd      = '{arg2: '0, arg1: '0, kind: flush_code_q};
								tail_nx = nxt_pos(tail_q);
								cnt_nx  = cnt_q + 1'b1;
							end
						end
						default: begin
							push = 1'b1;
						end
					endcase
				end
			end
			S_GET: begin
				push     = 1'b1;
				res_msg  = rd_data_s1;
				head_nx  = nxt_pos(head_q);
				cnt_nx   = cnt_q - 1'b1;
				state_nx = S_IDLE;
			end
			S_PURGE: begin
				// entry read last cycle is checked; kept ones are compacted at wr
				if (keep) begin
					we      = 1'b1;
					wa      = wr_q;
					wd      = rd_data_s1;
					wr_nx   = nxt_pos(wr_q);
					kept_nx = kept_q + 1'b1;
				end
				if (iss_q == cnt_q) begin
					push     = 1'b1;
					cnt_nx   = kept_nx;
					tail_nx  = wr_nx;
					state_nx = S_IDLE;
				end else begin
					ra     = rd_q;
					rd_nx  = nxt_pos(rd_q);
					iss_nx = iss_q + 1'b1;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			cnt_q        <= '0;
			abort_q      <= 1'b1;
			flush_code_q <= '0;
			rd_q         <= '0;
			wr_q         <= '0;
			iss_q        <= '0;
			kept_q       <= '0;
			ptype_q      <= '0;
		end else begin
			state_q <= state_nx;
			head_q  <= head_nx;
			tail_q  <= tail_nx;
			cnt_q   <= cnt_nx;
			abort_q <= abort_nx;
			rd_q    <= rd_nx;
			wr_q    <= wr_nx;
			iss_q   <= iss_nx;
			kept_q  <= kept_nx;
			ptype_q <= ptype_nx;
			if (cfg_valid && cfg_ready) flush_code_q <= cfg_data;
		end
	end

	// during a purge, read and write never hit the same entry: the write trails its read
	always_ff @(posedge clk) begin
		if (we) store_q[wa] <= wd;
		rd_data_s1 <= store_q[ra];
	end

	assign res_data = {cnt_nx, res_msg, res_status};

	mfp_out_buf #(
		.W(RES_W)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res_data),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (buf_data)
	);

	assign m_tuser = buf_data[1:0];
	generate
		if (PAD_W > 0) begin : g_pad
			assign m_tdata = {{PAD_W{1'b0}}, buf_data[RES_W-1:2]};
		end else begin : g_nopad
			assign m_tdata = buf_data[RES_W-1:2];
		end
	endgenerate

endmodule

// ===== design/mfp_chk.sv =====
// mfp_chk: port-level checks on the message queue results, bound to the
// top level at the end of this file. depends on mfp_pkg.
module mfp_chk
	import mfp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	input logic [1:0] m_tuser,
	input logic [((3*32+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_tdata,
	input logic m_tvalid,
	input logic m_tready
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0] occ;
	assign occ = m_tdata[MSG_W+CNT_W-1:MSG_W];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> occ <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy beyond queue depth");

	// only a delivered get carries a message
	a_zero_msg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[MSG_W-1:0] == '0)
		else $error("message bits set on a failed request");

	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != ST_EMPTY || occ == '0) &&
		(m_tuser != ST_FULL || occ == CNT_W'(QUEUE_DEPTH)))
		else $error("status disagrees with occupancy");

endmodule

bind message_fifo_with_purge mfp_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mfp_chk (.*);
